/* hw/rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define AWS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awsynth check failed");

// condition in this cycle implies consequence in the next cycle
`define AWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awsynth check failed");

`endif

/* hw/rtl/awsynth_pkg.sv */
// shared types, constants and the sine table generator of the additive wave synth
// no dependencies
package awsynth_pkg;

  localparam int WAVE_SLOTS                = 4;
  localparam int NUM_WAVES_DEFAULT         = 4;
  localparam int SINE_TABLE_DEPTH_DEFAULT  = 1024;

  localparam int PHASE_W  = 16;
  localparam int AMP_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int HEIGHT_W = 19;
  localparam int TERM_W   = 19;
  localparam int SUM_W    = TERM_W + 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [PHASE_W-1:0] FRAME_PHASE_STEP = 16'd209;
  localparam logic [PHASE_W-1:0] COS_OFFSET       = 16'h4000;
  localparam logic [AMP_W-1:0]   AMP_RESET        = 16'd5120;
  localparam logic [PHASE_W-1:0] STEP_RESET       = 16'd2621;

  localparam int HEIGHT_MAX = (1 << (HEIGHT_W - 1)) - 1;
  localparam int HEIGHT_MIN = -(1 << (HEIGHT_W - 1));

  // register map, one 16-bit register per word
  typedef enum logic [2:0] {
    REG_AMP0  = 3'd0,
    REG_AMP1  = 3'd1,
    REG_AMP2  = 3'd2,
    REG_AMP3  = 3'd3,
    REG_STEP0 = 3'd4,
    REG_STEP1 = 3'd5,
    REG_STEP2 = 3'd6,
    REG_STEP3 = 3'd7
  } reg_idx_t;

  localparam logic [63:0] QONE = 64'd1 << 30;

  // first-quarter sine in Q1.15, taylor series through the 9th power in Q30
  function automatic logic [15:0] quarter_sine(input logic [14:0] q);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    a  = 64'(q) * 64'd102944;
    a2 = (a * a) >> 30;
    t  = QONE - a2 / 64'd72;
    t  = QONE - ((a2 * t) >> 30) / 64'd42;
    t  = QONE - ((a2 * t) >> 30) / 64'd20;
    t  = QONE - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  // full-turn sine by folding into the first quarter
  function automatic logic signed [15:0] phase_sine(input logic [15:0] p);
    logic [14:0] q;
    logic [15:0] v;
    q = {1'b0, p[13:0]};
    if (p[14]) begin
      q = 15'd16384 - q;
    end
    v = quarter_sine(q);
    return p[15] ? -v : v;
  endfunction

endpackage

/* hw/rtl/awsynth_sine_rom.sv */
// sine lookup: phase to table index, constant table, registered read
// depends on awsynth_pkg for the table generator and widths
module awsynth_sine_rom import awsynth_pkg::*; #(
  parameter int DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [PHASE_W-1:0]         phase,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int MUL_W = PHASE_W + $clog2(DEPTH + 1);

  logic signed [SAMPLE_W-1:0] rom_word [DEPTH];
  logic [MUL_W-1:0]           scaled;
  logic [IDX_W-1:0]           idx;

  // table contents fixed at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [PHASE_W-1:0] ENTRY_PHASE = PHASE_W'((k * 65536) / DEPTH);
    localparam logic signed [SAMPLE_W-1:0] ENTRY_VALUE = phase_sine(ENTRY_PHASE);
    assign rom_word[k] = ENTRY_VALUE;
  end

  // index = floor(phase * depth / one turn)
  assign scaled = MUL_W'(phase) * MUL_W'(DEPTH);
  assign idx    = IDX_W'(scaled >> PHASE_W);

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      sample <= rom_word[idx];
    end
  end

endmodule

/* hw/rtl/additive_wave_synth.sv */
// additive wave synth: one height sample per input beat, the sum of up to four
// weighted sine/cosine oscillators read from a constant sine table.
// input channel: in_valid/in_ready with row_start. when row_start is set the
// global phase first advances by a fixed step and every wave phase is reloaded
// with it; the sample then uses the wave phases, which advance by their steps.
// output channel: out_valid/out_ready with height, signed Q10.8, saturated.
// the result passes four registers from input beat to out_valid (phase register, table
// read, multiply and round, sum and saturate). throughput: one beat per cycle while in_ready
// is high, set by the oscillator phase update, which completes in the accepting cycle.
// a stalled receiver holds the result in the output register; the stages
// behind it keep filling and in_ready drops only when all four are full.
// reset (synchronous, rst high) empties the pipe, clears global and wave
// phases and loads default amplitudes and phase steps. configuration is an apb-style
// port, one 16-bit register per word; the user writes it only while the block idles,
// which the block does not enforce. depends on awsynth_pkg and awsynth_sine_rom
module additive_wave_synth import awsynth_pkg::*; #(
  parameter int NUM_WAVES        = NUM_WAVES_DEFAULT,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       row_start,
  // result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [HEIGHT_W-1:0] height,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [AMP_W-1:0]   amplitude  [WAVE_SLOTS];
  logic [PHASE_W-1:0] phase_step [WAVE_SLOTS];

  logic [PHASE_W-1:0] global_phase;
  logic [PHASE_W-1:0] global_phase_next;
  logic [PHASE_W-1:0] wave_phase [NUM_WAVES];
  logic [PHASE_W-1:0] cur_phase  [NUM_WAVES];

  logic in_fire;
  logic wr_en;
  reg_idx_t wr_idx;

  logic en1, en2, en3, en_o;
  logic s1_valid, s2_valid, s3_valid;

  logic [PHASE_W-1:0]         s1_phase  [NUM_WAVES];
  logic signed [SAMPLE_W-1:0] s2_sample [NUM_WAVES];
  logic signed [TERM_W-1:0]   term      [NUM_WAVES];
  logic signed [TERM_W-1:0]   s3_term   [NUM_WAVES];
  logic signed [SUM_W-1:0]    sum;
  logic signed [HEIGHT_W-1:0] height_next;

  // stage enables: a stage loads when its next stage is empty or moving on
  assign en_o     = !out_valid || out_ready;
  assign en3      = !s3_valid || en_o;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;
  assign in_fire  = in_valid && in_ready;

  // configuration write and read
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WAVE_SLOTS; j++) begin
        amplitude[j]  <= AMP_RESET;
        phase_step[j] <= STEP_RESET;
      end
    end else if (wr_en) begin
      case (wr_idx)
        REG_AMP0:  amplitude[0]  <= pwdata[AMP_W-1:0];
        REG_AMP1:  amplitude[1]  <= pwdata[AMP_W-1:0];
        REG_AMP2:  amplitude[2]  <= pwdata[AMP_W-1:0];
        REG_AMP3:  amplitude[3]  <= pwdata[AMP_W-1:0];
        REG_STEP0: phase_step[0] <= pwdata[PHASE_W-1:0];
        REG_STEP1: phase_step[1] <= pwdata[PHASE_W-1:0];
        REG_STEP2: phase_step[2] <= pwdata[PHASE_W-1:0];
        REG_STEP3: phase_step[3] <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_AMP0:  prdata = DATA_W'(amplitude[0]);
      REG_AMP1:  prdata = DATA_W'(amplitude[1]);
      REG_AMP2:  prdata = DATA_W'(amplitude[2]);
      REG_AMP3:  prdata = DATA_W'(amplitude[3]);
      REG_STEP0: prdata = DATA_W'(phase_step[0]);
      REG_STEP1: prdata = DATA_W'(phase_step[1]);
      REG_STEP2: prdata = DATA_W'(phase_step[2]);
      REG_STEP3: prdata = DATA_W'(phase_step[3]);
      default:   prdata = '0;
    endcase
  end

  // oscillator phases for this beat: reload from the advanced global phase on a row start
  assign global_phase_next = global_phase + FRAME_PHASE_STEP;

  always_comb begin
    for (int j = 0; j < NUM_WAVES; j++) begin
      cur_phase[j] = row_start ? global_phase_next : wave_phase[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_phase <= '0;
      for (int j = 0; j < NUM_WAVES; j++) begin
        wave_phase[j] <= '0;
      end
    end else if (in_fire) begin
      if (row_start) begin
        global_phase <= global_phase_next;
      end
      for (int j = 0; j < NUM_WAVES; j++) begin
        wave_phase[j] <= cur_phase[j] + phase_step[j];
      end
    end
  end

  // stage 1: table phase per wave, odd waves shifted a quarter turn for cosine
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int j = 0; j < NUM_WAVES; j++) begin
        s1_phase[j] <= (j % 2 == 1) ? cur_phase[j] + COS_OFFSET : cur_phase[j];
      end
    end
  end

  // stage 2: table reads, one per wave
  for (genvar j = 0; j < NUM_WAVES; j++) begin : g_wave
    logic signed [AMP_W:0]            amp_s;
    logic signed [AMP_W+SAMPLE_W:0]   prod;
    logic signed [AMP_W+SAMPLE_W+1:0] rounded;

    awsynth_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
      .clk    (clk),
      .en     (en2),
      .phase  (s1_phase[j]),
      .sample (s2_sample[j])
    );

    // amplitude times sample, rounded to Q.8
    assign amp_s   = $signed({1'b0, amplitude[j]});
    assign prod    = (AMP_W + SAMPLE_W + 1)'(amp_s) * (AMP_W + SAMPLE_W + 1)'(s2_sample[j]);
    assign rounded = (AMP_W + SAMPLE_W + 2)'(prod) + (AMP_W + SAMPLE_W + 2)'(16384);
    assign term[j] = rounded[AMP_W+SAMPLE_W+1:15];
  end

  // stage 3: rounded terms
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int j = 0; j < NUM_WAVES; j++) begin
        s3_term[j] <= term[j];
      end
    end
  end

  // sum and saturate
  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_WAVES; j++) begin
      sum = sum + SUM_W'(s3_term[j]);
    end
    if (sum > SUM_W'(HEIGHT_MAX)) begin
      height_next = HEIGHT_W'(HEIGHT_MAX);
    end else if (sum < SUM_W'(HEIGHT_MIN)) begin
      height_next = HEIGHT_W'(HEIGHT_MIN);
    end else begin
      height_next = sum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      height <= height_next;
    end
  end

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en_o) begin
        out_valid <= s3_valid;
      end
    end
  end

endmodule

/* hw/rtl/awsynth_checker.sv */
// port-level checks for the additive wave synth, bound to the top level
// depends on assert_macros.svh and awsynth_pkg
`include "assert_macros.svh"

module awsynth_checker import awsynth_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [HEIGHT_W-1:0] height,
  input logic                       pready
);

  // the config port never inserts wait states
  `AWS_ASSERT_NOW(a_pready_high, clk, rst, 1'b1, pready)

  // input is held off only when the whole pipe is full behind a stalled result
  `AWS_ASSERT_NOW(a_stall_only_when_full, clk, rst, !in_ready, out_valid && !out_ready)

  // nothing is offered in the first cycle after reset
  `AWS_ASSERT_NOW(a_quiet_after_reset, clk, rst, $fell(rst), !out_valid)

  // a stalled result stays put
  `AWS_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready,
    out_valid && $stable(height))

endmodule

bind additive_wave_synth awsynth_checker u_checker (.*);
